>>> hdl/cbrt_pkg.sv
// Shared types and constants for the block residency table.
package cbrt_pkg;

  localparam int NUM_ENTRIES  = 256;
  localparam int IDX_W        = $clog2(NUM_ENTRIES);
  localparam int WINDOW_DEPTH = 5;
  localparam int WCNT_W       = $clog2(WINDOW_DEPTH + 1);
  localparam int TIME_W       = 64;
  localparam int ORDER_W      = 32;
  localparam int CNT_W        = 8;
  localparam int TOTAL_W      = 9;
  localparam logic [CNT_W-1:0] READER_MAX = '1;

  typedef enum logic [2:0] {
    OP_ACCESS  = 3'd0,
    OP_FILL    = 3'd1,
    OP_RELEASE = 3'd2,
    OP_BACKOUT = 3'd3,
    OP_EVICT   = 3'd4,
    OP_CHECK   = 3'd5
  } op_t;

  typedef struct packed {
    logic present;
    logic reserve;
    logic success;
    logic [7:0] victim_index;
    logic may_grow;
    logic streaming;
    logic pattern_changed;
    logic [TOTAL_W-1:0] resident_count;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture input word
    logic rd;         // read entry at captured index
    logic exec;       // apply single-entry op / check
    logic scan_start; // reset scan state, read entry 0
    logic scan_step;  // compare entry on read port, read next
    logic evict_do;   // commit victim
  } cmd_t;

  typedef struct packed {
    logic scan_last; // entry being compared is the last one
  } stat_t;

endpackage

>>> hdl/cbrt_datapath.sv
// Entry memories, window, pattern logic and eviction scan datapath.
module cbrt_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  cbrt_pkg::cmd_t        cmd,
  output cbrt_pkg::stat_t       stat,
  input  logic [2:0]            opcode,
  input  logic [7:0]            block_index,
  input  logic [63:0]           now,
  input  logic                  track,
  input  logic                  reserve_in,
  output cbrt_pkg::result_t     result
);
  import cbrt_pkg::*;

  logic [NUM_ENTRIES-1:0] resident;
  logic [NUM_ENTRIES-1:0] cnt_valid;
  logic [CNT_W-1:0]   cnt_mem  [NUM_ENTRIES];
  logic [TIME_W-1:0]  time_mem [NUM_ENTRIES];
  logic [ORDER_W-1:0] order_mem[NUM_ENTRIES];

  logic [2:0]        op_r;
  logic [7:0]        idx_r;
  logic [TIME_W-1:0] now_r;
  logic              track_r, rsv_r;

  logic [CNT_W-1:0]   cnt_q;
  logic               cnt_v_q;
  logic [TIME_W-1:0]  time_q;
  logic [ORDER_W-1:0] order_q;
  logic               res_q;

  logic [ORDER_W-1:0] fill_counter;
  logic [IDX_W-1:0]   walk_idx, cmp_idx;
  logic               found;
  logic [IDX_W-1:0]   best;
  logic [TIME_W-1:0]  best_time;
  logic [ORDER_W-1:0] best_age;

  logic [7:0]         recent [WINDOW_DEPTH];
  logic [WCNT_W-1:0]  recent_count;
  logic               pattern_bit;
  logic [TOTAL_W-1:0] block_total;

  logic               idx_ok;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic               cnt_wr;
  logic [CNT_W-1:0]   cnt;
  logic [ORDER_W-1:0] age;
  logic               stride_ok, next_pat;
  result_t            result_next;

  assign idx_ok  = ({1'b0, idx_r} < 9'(NUM_ENTRIES));
  assign idx     = IDX_W'(idx_r);
  assign cnt     = cnt_v_q ? cnt_q : '0;
  assign age     = fill_counter - order_q;
  assign rd_en   = cmd.rd || cmd.scan_start || cmd.scan_step;
  assign rd_addr = cmd.rd ? idx : (cmd.scan_start ? '0 : walk_idx);
  assign cnt_wr  = idx_ok && ((op_r == OP_ACCESS && track_r) || op_r == OP_FILL ||
                              op_r == OP_RELEASE || op_r == OP_BACKOUT);
  assign stat.scan_last = (cmp_idx == IDX_W'(NUM_ENTRIES - 1));

  always_comb begin
    stride_ok = 1'b1;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      if (i < int'(recent_count) && (recent[i-1] < recent[i] ||
          recent[i-1] - recent[i] > 8'd1)) begin
        stride_ok = 1'b0;
      end
    end
    next_pat = (recent_count > WCNT_W'(2)) ? stride_ok : pattern_bit;
  end

  always_comb begin
    result_next = '0;
    result_next.streaming = pattern_bit;
    result_next.resident_count = block_total;
    if (cmd.load) begin
      result_next = '0;
    end else if (cmd.exec) begin
      if (idx_ok) begin
        unique case (op_r)
          OP_ACCESS: begin
            result_next.present = res_q;
            result_next.reserve = res_q ? 1'b0 : (track_r ? (cnt == '0) : rsv_r);
          end
          OP_FILL: begin
            if (!res_q) result_next.resident_count = block_total + 1'b1;
          end
          OP_BACKOUT: result_next.success = (cnt == CNT_W'(1));
          default: ;
        endcase
      end
      if (op_r == OP_CHECK) begin
        result_next.may_grow = !(next_pat && block_total != '0);
        result_next.pattern_changed = (next_pat != pattern_bit);
        result_next.streaming = next_pat;
      end
    end else if (cmd.evict_do) begin
      if (found) begin
        if (block_total != '0) result_next.resident_count = block_total - 1'b1;
        result_next.success = 1'b1;
        result_next.victim_index = 8'(best);
      end
    end
  end

  // Entry memory reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_q   <= cnt_mem[rd_addr];
      time_q  <= time_mem[rd_addr];
      order_q <= order_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_v_q <= cnt_valid[rd_addr];
      res_q   <= resident[rd_addr];
    end
  end

  // Entry memory writes
  always_ff @(posedge clk) begin
    if (cmd.exec && idx_ok) begin
      if (op_r == OP_ACCESS && track_r) begin
        cnt_mem[idx] <= (cnt != READER_MAX) ? cnt + 1'b1 : cnt;
      end else if (op_r == OP_FILL || op_r == OP_RELEASE) begin
        cnt_mem[idx] <= (cnt != '0) ? cnt - 1'b1 : cnt;
      end else if (op_r == OP_BACKOUT) begin
        cnt_mem[idx] <= (cnt == CNT_W'(1)) ? '0 : cnt;
      end
      if ((op_r == OP_ACCESS && res_q) || op_r == OP_FILL) begin
        time_mem[idx] <= now_r;
      end
      if (op_r == OP_FILL && !res_q) begin
        order_mem[idx] <= fill_counter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode; idx_r <= block_index; now_r <= now;
      track_r <= track; rsv_r <= reserve_in;
    end
    if (cmd.exec && op_r == OP_ACCESS && idx_ok) begin
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) recent[i] <= recent[i-1];
      recent[0] <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resident <= '0; cnt_valid <= '0; fill_counter <= '0;
      recent_count <= '0; pattern_bit <= 1'b0; block_total <= '0;
      walk_idx <= '0; cmp_idx <= '0; found <= 1'b0; best <= '0;
      result <= '0;
    end else begin
      if (cmd.load || cmd.exec || cmd.evict_do) result <= result_next;
      if (cmd.exec) begin
        if (cnt_wr) cnt_valid[idx] <= 1'b1;
        if (idx_ok) begin
          if (op_r == OP_ACCESS && recent_count < WCNT_W'(WINDOW_DEPTH)) begin
            recent_count <= recent_count + 1'b1;
          end
          if (op_r == OP_FILL && !res_q) begin
            resident[idx] <= 1'b1;
            fill_counter <= fill_counter + 1'b1;
            block_total <= block_total + 1'b1;
          end
        end
        if (op_r == OP_CHECK) pattern_bit <= next_pat;
      end
      if (cmd.scan_start) begin
        found <= 1'b0;
        cmp_idx <= '0;
        walk_idx <= IDX_W'(1);
      end
      if (cmd.scan_step) begin
        cmp_idx <= walk_idx;
        walk_idx <= walk_idx + 1'b1;
        if (res_q && cnt == '0 && (!found || time_q < best_time ||
            (time_q == best_time && age > best_age))) begin
          found <= 1'b1; best <= cmp_idx; best_time <= time_q; best_age <= age;
        end
      end
      if (cmd.evict_do && found) begin
        resident[best] <= 1'b0;
        if (block_total != '0) block_total <= block_total - 1'b1;
      end
    end
  end
endmodule

>>> hdl/cbrt_ctrl.sv
// Sequencing controller with output word register handshake.
module cbrt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic [2:0]       opcode,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cbrt_pkg::cmd_t   cmd,
  input  cbrt_pkg::stat_t  stat
);
  import cbrt_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_SCAN, S_COMMIT, S_OUT} state_t;
  state_t state;
  logic [2:0] opcode_r;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    unique case (state)
      S_READ:  if (opcode_r == OP_EVICT) cmd.scan_start = 1'b1; else cmd.rd = 1'b1;
      S_EXEC:  cmd.exec = 1'b1;
      S_SCAN:  cmd.scan_step = 1'b1;
      S_COMMIT: cmd.evict_do = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; opcode_r <= '0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_fire) begin opcode_r <= opcode; state <= S_READ; end
        S_READ:  state <= (opcode_r == OP_EVICT) ? S_SCAN : S_EXEC;
        S_EXEC:  begin out_valid <= 1'b1; state <= S_OUT; end
        S_SCAN:  if (stat.scan_last) state <= S_COMMIT;
        S_COMMIT: begin out_valid <= 1'b1; state <= S_OUT; end
        S_OUT:   if (out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/cache_block_residency_table_core.sv
// Top level of the block residency table.
// Usage:
//   s_axis carries one operation word: tdata {reserve_in, track, now,
//   block_index, opcode}. m_axis returns one result word per operation.
//   Operations are handled one at a time. Access, fill, release, back out
//   and check read the entry, then update it, before the result is valid.
//   Evict walks every entry through the single read port of the entry
//   memories, then commits the victim.
//   s_axis_tready is high only while idle; a new word can be taken in the
//   cycle after the previous result is taken.
//   A stalled receiver holds the result in the output register and the
//   block takes no new word until it is taken.
//   Reset clears all residency flags and reader counts at once, the
//   window, the pattern, the fill counter and the resident count.
module cache_block_residency_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], block_index[10:3], now[74:11], track[75], reserve_in[76]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // present[0], reserve[1], success[2], victim_index[10:3], may_grow[11],
  // streaming[12], pattern_changed[13], resident_count[22:14]
  output logic [23:0] m_axis_tdata
);
  import cbrt_pkg::*;

  cmd_t    cmd;
  stat_t   stat;
  result_t res;
  logic    in_fire;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  cbrt_ctrl u_ctrl (
    .clk, .rst, .in_fire, .opcode(s_axis_tdata[2:0]),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .cmd, .stat
  );

  cbrt_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .opcode(s_axis_tdata[2:0]), .block_index(s_axis_tdata[10:3]),
    .now(s_axis_tdata[74:11]), .track(s_axis_tdata[75]),
    .reserve_in(s_axis_tdata[76]), .result(res)
  );

  assign m_axis_tdata = {1'b0, res.resident_count, res.pattern_changed, res.streaming,
                         res.may_grow, res.victim_index, res.success, res.reserve,
                         res.present};
endmodule

>>> hdl/cbrt_checker.sv
// Port-level checker for the block residency table.
module cbrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[22:14] <= 9'd256) else $error("count range");
  a_victim: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[10:3] == 8'd0)
    else $error("victim without success");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1])) else $error("reserve on hit");
endmodule

bind cache_block_residency_table_core cbrt_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

>>> verif/tb_top.sv
// Self-checking testbench for the block residency table core.
module tb_top;
  import cbrt_pkg::*;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [63:0] now;
    logic        track;
    logic        rsv;
    logic        has_exp;
    logic [23:0] exp_word;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  cache_block_residency_table_core i_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic              tbl_res [NUM_ENTRIES];
  logic [CNT_W-1:0]  tbl_cnt [NUM_ENTRIES];
  logic [63:0]       tbl_time [NUM_ENTRIES];
  logic [31:0]       tbl_order [NUM_ENTRIES];
  logic [31:0]       fills;
  logic [7:0]        win [WINDOW_DEPTH];
  int                win_n;
  logic              pat;
  logic [8:0]        total;

  logic [23:0] expected_words[$];
  stim_t       dir[$];
  int errors = 0;
  int src_idle = 18, snk_idle = 82;
  logic hold_req = 1'b0;
  int hold_cycles = 0;

  function automatic logic [23:0] predict(logic [2:0] op, logic [7:0] idx, logic [63:0] now,
                                          logic track, logic rsv);
    result_t r;
    logic found;
    int best;
    logic [63:0] bt;
    logic [31:0] ba, age;
    logic nxt;
    r = '0;
    case (op)
      OP_ACCESS: begin
        for (int i = WINDOW_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = idx;
        if (win_n < WINDOW_DEPTH) win_n++;
        r.reserve = rsv;
        if (track) begin
          r.reserve = (tbl_cnt[idx] == 0);
          if (tbl_cnt[idx] != READER_MAX) tbl_cnt[idx]++;
        end
        if (tbl_res[idx]) begin
          r.present = 1'b1;
          tbl_time[idx] = now;
          r.reserve = 1'b0;
        end
      end
      OP_FILL: begin
        if (!tbl_res[idx]) begin
          tbl_res[idx] = 1'b1;
          tbl_order[idx] = fills;
          fills++;
          total++;
        end
        tbl_time[idx] = now;
        if (tbl_cnt[idx] != 0) tbl_cnt[idx]--;
      end
      OP_RELEASE: if (tbl_cnt[idx] != 0) tbl_cnt[idx]--;
      OP_BACKOUT: if (tbl_cnt[idx] == 1) begin
        tbl_cnt[idx] = '0;
        r.success = 1'b1;
      end
      OP_EVICT: begin
        found = 1'b0; best = 0; bt = '0; ba = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
          if (tbl_res[i] && tbl_cnt[i] == 0) begin
            age = fills - tbl_order[i];
            if (!found || tbl_time[i] < bt || (tbl_time[i] == bt && age > ba)) begin
              found = 1'b1; best = i; bt = tbl_time[i]; ba = age;
            end
          end
        end
        if (found) begin
          tbl_res[best] = 1'b0;
          if (total != 0) total--;
          r.success = 1'b1;
          r.victim_index = best[7:0];
        end
      end
      OP_CHECK: begin
        nxt = pat;
        if (win_n > 2) begin
          nxt = 1'b1;
          for (int i = 1; i < win_n; i++)
            if (!(win[i-1] == win[i] || win[i-1] == win[i] + 9'd1)) nxt = 1'b0;
        end
        r.may_grow = !(nxt && total != 0);
        if (nxt != pat) begin
          r.pattern_changed = 1'b1;
          pat = nxt;
        end
      end
      default: ;
    endcase
    r.streaming = pat;
    r.resident_count = total;
    return {1'b0, r.resident_count, r.pattern_changed, r.streaming, r.may_grow,
            r.victim_index, r.success, r.reserve, r.present};
  endfunction

  task automatic send_word(stim_t s);
    logic [23:0] e;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= {3'b0, s.rsv, s.track, s.now, s.idx, s.op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    e = predict(s.op, s.idx, s.now, s.track, s.rsv);
    if (s.has_exp && e !== s.exp_word) begin
      $display("%0t: table row disagrees with predictor: exp %h pred %h", $time, s.exp_word, e);
      errors++;
    end
    expected_words.insert(expected_words.size(), e);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, exp none act %h", $time, m_axis_tdata);
          errors++;
        end else begin
          if (m_axis_tdata !== expected_words[0]) begin
            $display("%0t: mismatch exp %h act %h", $time, expected_words[0], m_axis_tdata);
            errors++;
          end
          void'(expected_words.pop_front());
        end
      end
      if (hold_req && hold_cycles < 400) begin
        hold_cycles++;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  function automatic stim_t mk(logic [2:0] op, logic [7:0] idx, logic [63:0] now,
                               logic track, logic rsv, logic he, logic [23:0] ew);
    stim_t s;
    s.op = op; s.idx = idx; s.now = now; s.track = track; s.rsv = rsv;
    s.has_exp = he; s.exp_word = ew;
    return s;
  endfunction

  function automatic void add_row(stim_t s);
    dir.insert(dir.size(), s);
  endfunction

  // random item biased toward a small working set and stride streams
  function automatic stim_t rand_item(int n);
    stim_t s;
    int k;
    logic [2:0] ops [10] = '{OP_ACCESS, OP_ACCESS, OP_ACCESS, OP_FILL, OP_FILL,
                             OP_RELEASE, OP_BACKOUT, OP_EVICT, OP_CHECK, OP_CHECK};
    k = $urandom_range(99);
    s.op = (k < 2) ? 3'($urandom_range(6, 7)) : ops[$urandom_range(9)];
    s.idx = ($urandom_range(9) == 0) ? 8'($urandom) :
            ($urandom_range(2) == 0) ? 8'(n / 3) : 8'($urandom_range(15) + 240 * (n & 1));
    case ($urandom_range(3))
      0: s.now = {$urandom, $urandom};
      1: s.now = 64'($urandom_range(20));
      2: s.now = '1 - 64'($urandom_range(3));
      default: s.now = 64'(n);
    endcase
    s.track = 1'($urandom); s.rsv = 1'($urandom);
    s.has_exp = 1'b0; s.exp_word = '0;
    return s;
  endfunction

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_res[i] = 1'b0; tbl_cnt[i] = '0; tbl_time[i] = '0; tbl_order[i] = '0;
    end
    for (int i = 0; i < WINDOW_DEPTH; i++) win[i] = '0;
    fills = '0; win_n = 0; pat = 1'b0; total = '0;

    // after reset: evict empty, check keeps unknown with may_grow 1
    add_row(mk(OP_EVICT, 8'd0, 64'd0, 1'b0, 1'b0, 1'b1, 24'h000000));
    add_row(mk(OP_CHECK, 8'd0, 64'd0, 1'b0, 1'b0, 1'b1, 24'h000800));
    add_row(mk(3'd6, 8'd9, '1, 1'b1, 1'b1, 1'b1, 24'h000000));
    add_row(mk(3'd7, 8'd9, '1, 1'b1, 1'b1, 1'b1, 24'h000000));
    add_row(mk(OP_ACCESS, 8'd0, 64'd5, 1'b1, 1'b0, 1'b1, 24'h000002));
    add_row(mk(OP_ACCESS, 8'd0, 64'd5, 1'b0, 1'b1, 1'b1, 24'h000002));
    add_row(mk(OP_BACKOUT, 8'd0, 64'd0, 1'b0, 1'b0, 1'b1, 24'h000004));
    add_row(mk(OP_RELEASE, 8'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_ACCESS, 8'd1, '1, 1'b1, 1'b0, 1'b0, '0));
    add_row(mk(OP_BACKOUT, 8'd1, 64'd0, 1'b0, 1'b0, 1'b1, 24'h000004));
    add_row(mk(OP_FILL, 8'd255, '1, 1'b0, 1'b0, 1'b1, 24'h004000));
    add_row(mk(OP_FILL, 8'd255, '1, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_FILL, 8'd2, '1, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_ACCESS, 8'd2, 64'd7, 1'b0, 1'b1, 1'b0, '0));
    add_row(mk(OP_ACCESS, 8'd3, 64'd7, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_CHECK, 8'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_EVICT, 8'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_EVICT, 8'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_ACCESS, 8'd200, 64'd1, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_CHECK, 8'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0));
    add_row(mk(OP_EVICT, 8'd0, 64'd0, 1'b0, 1'b0, 1'b0, '0));
    for (int i = 0; i < 3; i++) add_row(mk(OP_ACCESS, 8'd4, 64'd1, 1'b1, 1'b0, 1'b0, '0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir[i]) send_word(dir[i]);
    // saturate one reader count
    for (int i = 0; i < 260; i++) send_word(mk(OP_ACCESS, 8'd7, 64'd3, 1'b1, 1'b0, 1'b0, '0));

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 18 : (phase == 1) ? 82 : 0;
      snk_idle = (phase == 0) ? 82 : (phase == 1) ? 18 : 0;
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < 500; n++) send_word(rand_item(n));
    end
    s_axis_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (NUM_ENTRIES + 10) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
